// ===== design/sqmm_pkg.sv =====
// Shared constants and controller/datapath handshake types for the matrix multiplier.
`default_nettype none

package sqmm_pkg;

    // Matrix size and derived counts
    localparam int MATRIX_DIM = 4;
    localparam int CELLS      = MATRIX_DIM * MATRIX_DIM;

    // Field widths
    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int SUM_W  = 34;

    // Counter and address widths
    localparam int DIM_W  = $clog2(MATRIX_DIM);
    localparam int CELL_W = $clog2(CELLS);
    localparam int LOAD_W = $clog2(2 * CELLS);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              wr_en;
        logic              wr_sel_b;
        logic [CELL_W-1:0] wr_addr;
        logic              issue;
        logic [CELL_W-1:0] a_addr;
        logic [CELL_W-1:0] b_addr;
        logic              first_k;
        logic              last_k;
        logic              push;
        logic              push_last;
    } sqmm_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic sum_ready;
        logic out_free;
    } sqmm_sts_t;

endpackage

`default_nettype wire

// ===== design/sqmm_if.sv =====
// Valid/ready channel interfaces for matrix elements and product elements.
`default_nettype none

interface sqmm_elem_if;
    logic                              valid;
    logic                              ready;
    logic signed [sqmm_pkg::ELEM_W-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink (input valid, input element, output ready);
endinterface

interface sqmm_prod_if;
    logic                             valid;
    logic                             ready;
    logic signed [sqmm_pkg::SUM_W-1:0] product_value;
    logic                             last_of_run;

    modport source (output valid, output product_value, output last_of_run, input ready);
    modport sink (input valid, input product_value, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== design/square_matrix_multiply.sv =====
// Square signed matrix multiplier: C = A * B over MATRIX_DIM by MATRIX_DIM integer matrices.
//
// operand channel: one 16-bit signed element per transaction, all of A row-major,
// then all of B row-major. One element is taken per cycle while loading.
// product channel: after the last element of B, the MATRIX_DIM*MATRIX_DIM elements
// of C leave in row-major order as 34-bit signed values; last_of_run marks the final one.
// One shared multiplier and accumulator does all N*N*N products. Each product element
// takes N operand reads; the read data is registered, multiplied into prod_reg and
// accumulated into acc_reg, and one push then moves the finished sum to the output register.
// No element is taken while the product is being computed; loading of the next run
// starts as soon as the last result is pushed to the output register.
// A stalled receiver holds the output register; the next sum waits in the accumulator
// and computation pauses until the register frees.
// Reset clears the controller and the output valid; the matrix stores are not cleared
// and every entry is written before it is read.
`default_nettype none

module square_matrix_multiply (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sqmm_elem_if.sink   operand,
    sqmm_prod_if.source product
);

    sqmm_pkg::sqmm_cmd_t cmd;
    sqmm_pkg::sqmm_sts_t sts;

    sqmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (operand.valid),
        .in_ready (operand.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sqmm_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .element (operand.element),
        .product (product)
    );

    // A push only moves a finished sum
    assert property (@(posedge clk) disable iff (!rst_n) cmd.push |-> sts.sum_ready)
        else $error("push without a finished sum");

    // A push never overwrites a result the receiver has not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!product.valid || product.ready))
        else $error("push overwrote a held result");

    // Operand reads never overlap element loading
    assert property (@(posedge clk) disable iff (!rst_n) cmd.issue |-> !operand.ready)
        else $error("operand read while loading");

    // A push is followed by a valid output
    assert property (@(posedge clk) disable iff (!rst_n) cmd.push |=> product.valid)
        else $error("pushed result not presented");

endmodule

`default_nettype wire

// ===== design/sqmm_dp.sv =====
// Datapath: matrix stores, shared multiply-accumulate pipeline and output register.
`default_nettype none

module sqmm_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire sqmm_pkg::sqmm_cmd_t                cmd,
    output sqmm_pkg::sqmm_sts_t                     sts,
    input  wire logic signed [sqmm_pkg::ELEM_W-1:0] element,
    sqmm_prod_if.source                             product
);

    localparam int CELLS  = sqmm_pkg::CELLS;
    localparam int ELEM_W = sqmm_pkg::ELEM_W;
    localparam int PROD_W = sqmm_pkg::PROD_W;
    localparam int SUM_W  = sqmm_pkg::SUM_W;

    logic signed [ELEM_W-1:0] first_mem [CELLS];
    logic signed [ELEM_W-1:0] second_mem [CELLS];

    logic signed [ELEM_W-1:0] a_q_reg;
    logic signed [ELEM_W-1:0] b_q_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_next;
    logic signed [SUM_W-1:0]  prod_ext;

    logic rd_valid_reg, rd_first_reg, rd_last_reg;
    logic mul_valid_reg, mul_first_reg, mul_last_reg;
    logic sum_ready_reg;

    logic                    out_valid_reg;
    logic signed [SUM_W-1:0] out_value_reg;
    logic                    out_last_reg;

    // Write loaded elements and read operands, read data registered
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && !cmd.wr_sel_b)
        begin
            first_mem[cmd.wr_addr] <= element;
        end
        if (cmd.wr_en && cmd.wr_sel_b)
        begin
            second_mem[cmd.wr_addr] <= element;
        end
        a_q_reg <= first_mem[cmd.a_addr];
        b_q_reg <= second_mem[cmd.b_addr];
    end

    // Multiply the operand pair and accumulate the products
    assign prod_ext = {{(SUM_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_next = mul_first_reg ? prod_ext : acc_reg + prod_ext;

    always_ff @(posedge clk)
    begin
        prod_reg <= a_q_reg * b_q_reg;
        if (mul_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.push)
        begin
            out_value_reg <= acc_reg;
            out_last_reg  <= cmd.push_last;
        end
    end

    // Advance the pipeline control flags and hold the output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            mul_valid_reg <= 1'b0;
            mul_first_reg <= 1'b0;
            mul_last_reg  <= 1'b0;
            sum_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= cmd.issue;
            rd_first_reg  <= cmd.first_k;
            rd_last_reg   <= cmd.last_k;
            mul_valid_reg <= rd_valid_reg;
            mul_first_reg <= rd_first_reg;
            mul_last_reg  <= rd_last_reg;
            if (cmd.push)
            begin
                sum_ready_reg <= 1'b0;
            end
            else if (mul_valid_reg && mul_last_reg)
            begin
                sum_ready_reg <= 1'b1;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (product.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.sum_ready = sum_ready_reg;
    assign sts.out_free  = !out_valid_reg || product.ready;

    assign product.valid         = out_valid_reg;
    assign product.product_value = out_value_reg;
    assign product.last_of_run   = out_last_reg;

endmodule

`default_nettype wire

// ===== design/sqmm_ctrl.sv =====
// Controller: load sequencing and multiply-accumulate scheduling state machine.
`default_nettype none

module sqmm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sqmm_pkg::sqmm_sts_t sts,
    output sqmm_pkg::sqmm_cmd_t      cmd
);

    localparam int MATRIX_DIM = sqmm_pkg::MATRIX_DIM;
    localparam int CELLS      = sqmm_pkg::CELLS;
    localparam int DIM_W      = sqmm_pkg::DIM_W;
    localparam int CELL_W     = sqmm_pkg::CELL_W;
    localparam int LOAD_W     = sqmm_pkg::LOAD_W;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_MAC   = 3'b010,
        ST_DRAIN = 3'b100
    } sqmm_state_t;

    sqmm_state_t state_reg, state_next;
    logic [LOAD_W-1:0] load_count_reg, load_count_next;
    logic [DIM_W-1:0]  i_reg, i_next;
    logic [DIM_W-1:0]  j_reg, j_next;
    logic [DIM_W-1:0]  k_reg, k_next;

    logic load_acc;
    logic load_done;
    logic k_end;
    logic j_end;
    logic i_end;
    logic push;

    assign load_acc  = in_valid && in_ready;
    assign load_done = load_count_reg == LOAD_W'(2 * CELLS - 1);
    assign k_end     = k_reg == DIM_W'(MATRIX_DIM - 1);
    assign j_end     = j_reg == DIM_W'(MATRIX_DIM - 1);
    assign i_end     = i_reg == DIM_W'(MATRIX_DIM - 1);
    assign push      = (state_reg == ST_DRAIN) && sts.sum_ready && sts.out_free;
    assign in_ready  = state_reg == ST_LOAD;

    // Drive datapath commands
    always_comb
    begin
        cmd.wr_en    = load_acc;
        cmd.wr_sel_b = load_count_reg >= LOAD_W'(CELLS);
        cmd.wr_addr  = cmd.wr_sel_b ? CELL_W'(load_count_reg - LOAD_W'(CELLS))
                                    : CELL_W'(load_count_reg);
        cmd.issue    = state_reg == ST_MAC;
        cmd.a_addr   = CELL_W'(CELL_W'(i_reg) * CELL_W'(MATRIX_DIM) + CELL_W'(k_reg));
        cmd.b_addr   = CELL_W'(CELL_W'(k_reg) * CELL_W'(MATRIX_DIM) + CELL_W'(j_reg));
        cmd.first_k  = k_reg == '0;
        cmd.last_k   = k_end;
        cmd.push     = push;
        cmd.push_last = i_end && j_end;
    end

    // Sequence loads, operand reads and result pushes
    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (load_acc)
                begin
                    if (load_done)
                    begin
                        load_count_next = '0;
                        i_next          = '0;
                        j_next          = '0;
                        k_next          = '0;
                        state_next      = ST_MAC;
                    end
                    else
                    begin
                        load_count_next = load_count_reg + 1'b1;
                    end
                end
            end
            ST_MAC:
            begin
                if (k_end)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (push)
                begin
                    if (i_end && j_end)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_MAC;
                        if (j_end)
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Hold controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
        end
    end

endmodule

`default_nettype wire

// ===== bench/square_matrix_multiply_test.sv =====
// Self-checking testbench for the square integer matrix multiplier.
`default_nettype none

module square_matrix_multiply_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MATRIX_DIM = sqmm_pkg::MATRIX_DIM;
    localparam int CELLS      = sqmm_pkg::CELLS;
    localparam int ELEM_W     = sqmm_pkg::ELEM_W;
    localparam int SUM_W      = sqmm_pkg::SUM_W;

    // How one matrix of a run is filled
    typedef enum {
        FILL_CONST, FILL_IDENTITY, FILL_RAMP, FILL_RANDOM, FILL_SMALL, FILL_EDGE
    } fill_t;

    typedef struct {
        fill_t                    a_kind;
        logic signed [ELEM_W-1:0] a_base;
        fill_t                    b_kind;
        logic signed [ELEM_W-1:0] b_base;
        bit                       typed;
        logic signed [SUM_W-1:0]  typed_value;
    } run_spec_t;

    typedef struct {
        bit                      typed;
        logic signed [SUM_W-1:0] value;
    } typed_sum_t;

    typedef struct {
        logic signed [SUM_W-1:0] value;
        logic                    last;
    } product_t;

    localparam int RANDOM_RUNS  = 5;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 40;
    localparam int DRAIN_CYCLES = 200;

    // Directed runs: uniform extremes have a sum that is plain to see
    localparam int DIRECTED_RUNS = 10;
    run_spec_t directed_runs [DIRECTED_RUNS] = '{
        '{FILL_CONST, 16'sh0000, FILL_CONST, 16'sh0000, 1'b1, 34'sd0},
        '{FILL_CONST, 16'sh8000, FILL_CONST, 16'sh8000, 1'b1, 34'sd4294967296},
        '{FILL_CONST, 16'sh8000, FILL_CONST, 16'sh7fff, 1'b1, -34'sd4294836224},
        '{FILL_CONST, 16'sh7fff, FILL_CONST, 16'sh7fff, 1'b1, 34'sd4294705156},
        '{FILL_CONST, 16'sh7fff, FILL_CONST, 16'sh8000, 1'b1, -34'sd4294836224},
        '{FILL_CONST, 16'shffff, FILL_CONST, 16'sh0001, 1'b1, -34'sd4},
        '{FILL_IDENTITY, 16'sh0001, FILL_RANDOM, 16'sh0000, 1'b0, 34'sd0},
        '{FILL_RANDOM, 16'sh0000, FILL_IDENTITY, 16'shffff, 1'b0, 34'sd0},
        '{FILL_RAMP, 16'sh7ff0, FILL_RAMP, 16'sh8003, 1'b0, 34'sd0},
        '{FILL_EDGE, 16'sh0000, FILL_EDGE, 16'sh0000, 1'b0, 34'sd0}
    };

    logic clk;
    logic rst_n;

    sqmm_elem_if operand_ch ();
    sqmm_prod_if product_ch ();

    square_matrix_multiply dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_ch),
        .product (product_ch)
    );

    // Predictor state
    logic signed [ELEM_W-1:0] a_cells [CELLS];
    logic signed [ELEM_W-1:0] b_cells [CELLS];
    int                       load_idx;
    typed_sum_t               run_typed_q [$];
    product_t                 pending_products [$];

    int  products_checked;
    int  mismatches;
    int  burst_left;
    logic long_hold;
    logic [7:0] stall_phase;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Store one accepted element; on the last element of B form the product
    function automatic void load_element(input logic signed [ELEM_W-1:0] v);
        longint     acc;
        product_t   p;
        typed_sum_t t;
        if (load_idx < CELLS)
            a_cells[load_idx] = v;
        else
            b_cells[load_idx - CELLS] = v;
        load_idx++;
        if (load_idx == 2 * CELLS)
        begin
            load_idx = 0;
            t.typed = 1'b0;
            t.value = '0;
            if (run_typed_q.size() != 0)
                t = run_typed_q.pop_front();
            for (int i = 0; i < MATRIX_DIM; i++)
            begin
                for (int j = 0; j < MATRIX_DIM; j++)
                begin
                    acc = 0;
                    for (int k = 0; k < MATRIX_DIM; k++)
                        acc += longint'(a_cells[i * MATRIX_DIM + k])
                             * longint'(b_cells[k * MATRIX_DIM + j]);
                    p.value = t.typed ? t.value : acc[SUM_W-1:0];
                    p.last  = (i == MATRIX_DIM - 1) && (j == MATRIX_DIM - 1);
                    pending_products.push_back(p);
                end
            end
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $time, msg);
    endfunction

    // Compare one product transaction with the oldest expectation
    function automatic void check_product(input logic signed [SUM_W-1:0] value,
                                          input logic last);
        product_t exp_p;
        if (pending_products.size() == 0)
        begin
            note_mismatch($sformatf("unexpected product value=%0d last=%0b", value, last));
            return;
        end
        exp_p = pending_products.pop_front();
        products_checked++;
        if (value !== exp_p.value)
            note_mismatch($sformatf("product_value expected %0d got %0d",
                                    exp_p.value, value));
        if (last !== exp_p.last)
            note_mismatch($sformatf("last_of_run expected %0b got %0b", exp_p.last, last));
    endfunction

    function automatic logic signed [ELEM_W-1:0] pick_element(input fill_t kind,
                                                             input logic signed [ELEM_W-1:0] base,
                                                             input int idx);
        logic signed [ELEM_W-1:0] v;
        case (kind)
            FILL_CONST:    v = base;
            FILL_IDENTITY: v = (idx / MATRIX_DIM == idx % MATRIX_DIM) ? base : '0;
            FILL_RAMP:     v = base + ELEM_W'(idx * 4099);
            FILL_SMALL:    v = ELEM_W'($urandom_range(0, 16)) - 16'sd8;
            FILL_EDGE:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7fff;
                    2:       v = 16'sh0000;
                    default: v = 16'shffff;
                endcase
            end
            default:       v = ELEM_W'($urandom);
        endcase
        return v;
    endfunction

    // Offer one element, with random gaps between bursts
    task automatic offer_element(input logic signed [ELEM_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                operand_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        operand_ch.valid   <= 1'b1;
        operand_ch.element <= v;
        do
            @(posedge clk);
        while (!(operand_ch.valid === 1'b1 && operand_ch.ready === 1'b1));
    endtask

    task automatic offer_run(input run_spec_t spec);
        typed_sum_t t;
        t.typed = spec.typed;
        t.value = spec.typed_value;
        run_typed_q.push_back(t);
        for (int idx = 0; idx < 2 * CELLS; idx++)
        begin
            if (idx < CELLS)
                offer_element(pick_element(spec.a_kind, spec.a_base, idx));
            else
                offer_element(pick_element(spec.b_kind, spec.b_base, idx - CELLS));
        end
    endtask

    function automatic fill_t random_fill();
        case ($urandom_range(0, 9))
            0:       return FILL_SMALL;
            1:       return FILL_EDGE;
            2:       return FILL_CONST;
            3:       return FILL_IDENTITY;
            default: return FILL_RANDOM;
        endcase
    endfunction

    // Track accepted elements
    always @(posedge clk)
    begin
        if (rst_n && operand_ch.valid === 1'b1 && operand_ch.ready === 1'b1)
            load_element(operand_ch.element);
    end

    // Check accepted products
    always @(posedge clk)
    begin
        if (rst_n && product_ch.valid === 1'b1 && product_ch.ready === 1'b1)
            check_product(product_ch.product_value, product_ch.last_of_run);
    end

    // Receiver stall pattern, cycling through modes
    always @(posedge clk)
    begin
        logic want;
        case (stall_phase[7:6])
            2'd0:    want = 1'b1;
            2'd1:    want = $urandom_range(0, 1);
            2'd2:    want = (stall_phase[1:0] == 2'd0);
            default: want = ($urandom_range(0, 9) != 0);
        endcase
        stall_phase      <= stall_phase + 8'd1;
        product_ch.ready <= want && !long_hold;
    end

    // Hold off the receiver once so the block backs up onto its input
    initial
    begin
        long_hold = 1'b0;
        wait (products_checked >= HOLD_AFTER);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Stimulus and end of run
    initial
    begin
        run_spec_t spec;
        rst_n              = 1'b0;
        operand_ch.valid   = 1'b0;
        operand_ch.element = '0;
        product_ch.ready   = 1'b0;
        stall_phase        = '0;
        load_idx           = 0;
        products_checked   = 0;
        mismatches         = 0;
        burst_left         = 0;
        for (int c = 0; c < CELLS; c++)
        begin
            a_cells[c] = '0;
            b_cells[c] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_runs[r])
            offer_run(directed_runs[r]);

        for (int r = 0; r < RANDOM_RUNS; r++)
        begin
            spec.a_kind      = random_fill();
            spec.a_base      = ELEM_W'($urandom);
            spec.b_kind      = random_fill();
            spec.b_base      = ELEM_W'($urandom);
            spec.typed       = 1'b0;
            spec.typed_value = '0;
            offer_run(spec);
        end
        operand_ch.valid <= 1'b0;

        // Let the tracker record the final element before waiting on the queue
        @(posedge clk);
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_products.size() == 0)
            $display("square_matrix_multiply: match");
        else
            $display("square_matrix_multiply: mismatch");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #2000000;
        $display("square_matrix_multiply: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
design/sqmm_pkg.sv
design/sqmm_if.sv
design/sqmm_dp.sv
design/sqmm_ctrl.sv
design/square_matrix_multiply.sv
bench/square_matrix_multiply_test.sv
